// ===== rtl/wid_pkg.sv =====
// Package: shared types and constants for the wide integer divider.
`timescale 1ns / 1ps

package wid_pkg;

    localparam int NumW  = 256;
    localparam int DenW  = 128;
    localparam int BitsPerStage = 4;
    localparam int DivStages = NumW / BitsPerStage;

    localparam logic CmdUnsigned = 1'b0;
    localparam logic CmdSigned   = 1'b1;

    // One pipeline item after operand preparation.
    typedef struct packed {
        logic [NumW-1:0] quo;    // numerator magnitude shifting into quotient
        logic [DenW:0]   rem;    // partial remainder, one guard bit
        logic [DenW-1:0] den;    // divisor magnitude
        logic            neg_quo;
        logic            neg_rem;
        logic            div_zero;
    } div_item_t;

endpackage

// ===== rtl/wide_integer_divider.sv =====
// Top level: pipelined 256 by 128 bit signed/unsigned integer divider.
`timescale 1ns / 1ps

// Accepts one division per clock while m_axis is not stalled and returns
// one result beat per division, in order. A prep register forms operand
// magnitudes, 64 stages each retire four quotient bits with a 129-bit
// subtract, and a fix-up stage restores signs into the output register. The
// whole pipeline advances together when the output register is empty or
// being taken, so a stall on m_axis holds every stage and loses nothing.
// Signed division truncates toward zero; the remainder follows the sign of
// the numerator; a zero divisor gives zero results with div_zero set.
module wide_integer_divider (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata fields from bit 0: num_w0, num_w1, num_w2, num_w3, den_w0, den_w1
    input  logic [383:0] s_axis_tdata,
    // tuser fields: cmd
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata fields from bit 0: quo_w0..quo_w3, rem_w0, rem_w1
    output logic [383:0] m_axis_tdata,
    // tuser fields: div_zero
    output logic         m_axis_tuser
);

    localparam int NS = wid_pkg::DivStages;

    logic                     en;
    logic                     stg_valid [NS+1];
    wid_pkg::div_item_t       stg_item  [NS+1];
    logic [wid_pkg::NumW-1:0] quo;
    logic [wid_pkg::DenW-1:0] rem;

    // Advance the whole pipe unless a finished beat is stuck at the output.
    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;

    wid_prep u_prep (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (s_axis_tvalid),
        .cmd       (s_axis_tuser),
        .num       (s_axis_tdata[wid_pkg::NumW-1:0]),
        .den       (s_axis_tdata[wid_pkg::NumW +: wid_pkg::DenW]),
        .out_valid (stg_valid[0]),
        .out_item  (stg_item[0])
    );

    for (genvar g = 0; g < NS; g++)
    begin : g_stage
        wid_stage u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (stg_valid[g]),
            .in_item   (stg_item[g]),
            .out_valid (stg_valid[g+1]),
            .out_item  (stg_item[g+1])
        );
    end

    wid_fix u_fix (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (stg_valid[NS]),
        .in_item   (stg_item[NS]),
        .out_valid (m_axis_tvalid),
        .quo       (quo),
        .rem       (rem),
        .div_zero  (m_axis_tuser)
    );

    assign m_axis_tdata = {rem, quo};

endmodule

// ===== rtl/wid_prep.sv =====
// Operand preparation: zero check, sign capture and magnitude forming.
`timescale 1ns / 1ps

module wid_prep (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       en,
    input  logic                       in_valid,
    input  logic                       cmd,
    input  logic [wid_pkg::NumW-1:0]   num,
    input  logic [wid_pkg::DenW-1:0]   den,
    output logic                       out_valid,
    output wid_pkg::div_item_t         out_item
);

    logic               valid_reg;
    wid_pkg::div_item_t item_reg;
    wid_pkg::div_item_t item_next;
    logic               sn;
    logic               sd;

    always_comb
    begin
        sn = (cmd == wid_pkg::CmdSigned) && num[wid_pkg::NumW-1];
        sd = (cmd == wid_pkg::CmdSigned) && den[wid_pkg::DenW-1];
        item_next.quo      = sn ? (~num + 1'b1) : num;
        item_next.den      = sd ? (~den + 1'b1) : den;
        item_next.rem      = '0;
        item_next.neg_quo  = sn ^ sd;
        item_next.neg_rem  = sn;
        item_next.div_zero = (den == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== rtl/wid_stage.sv =====
// One divider stage: retire BitsPerStage quotient bits by restoring steps.
`timescale 1ns / 1ps

module wid_stage (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               en,
    input  logic               in_valid,
    input  wid_pkg::div_item_t in_item,
    output logic               out_valid,
    output wid_pkg::div_item_t out_item
);

    logic               valid_reg;
    wid_pkg::div_item_t item_reg;
    wid_pkg::div_item_t item_next;
    logic [wid_pkg::DenW:0] diff;

    always_comb
    begin
        item_next = in_item;
        diff = '0;
        for (int i = 0; i < wid_pkg::BitsPerStage; i++)
        begin
            // shift next numerator bit in; remainder < den so DenW+1 bits hold it
            item_next.rem = {item_next.rem[wid_pkg::DenW-1:0],
                             item_next.quo[wid_pkg::NumW-1]};
            item_next.quo = {item_next.quo[wid_pkg::NumW-2:0], 1'b0};
            diff = item_next.rem - {1'b0, item_next.den};
            if (!diff[wid_pkg::DenW])
            begin
                item_next.rem    = diff;
                item_next.quo[0] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            item_reg <= item_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_item  = item_reg;

endmodule

// ===== rtl/wid_fix.sv =====
// Result fix-up: sign restore, zero-divisor forcing, output register.
`timescale 1ns / 1ps

module wid_fix (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     en,
    input  logic                     in_valid,
    input  wid_pkg::div_item_t       in_item,
    output logic                     out_valid,
    output logic [wid_pkg::NumW-1:0] quo,
    output logic [wid_pkg::DenW-1:0] rem,
    output logic                     div_zero
);

    logic                     valid_reg;
    logic [wid_pkg::NumW-1:0] quo_reg;
    logic [wid_pkg::DenW-1:0] rem_reg;
    logic                     zero_reg;
    logic [wid_pkg::NumW-1:0] quo_next;
    logic [wid_pkg::DenW-1:0] rem_next;

    always_comb
    begin
        quo_next = in_item.neg_quo ? (~in_item.quo + 1'b1) : in_item.quo;
        rem_next = in_item.rem[wid_pkg::DenW-1:0];
        rem_next = in_item.neg_rem ? (~rem_next + 1'b1) : rem_next;
        if (in_item.div_zero)
        begin
            quo_next = '0;
            rem_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            zero_reg <= in_item.div_zero;
        end
    end

    assign out_valid = valid_reg;
    assign quo       = quo_reg;
    assign rem       = rem_reg;
    assign div_zero  = zero_reg;

endmodule

// ===== rtl/wid_checker.sv =====
// Port checker for the wide integer divider, bound to the top level.
`timescale 1ns / 1ps

module wid_checker (
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [383:0] m_axis_tdata,
    input logic         m_axis_tuser
);

    // A stalled result beat holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result beat changed under stall");

    // Input is taken whenever the output is free.
    assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // Input stalls only while a result waits.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |-> m_axis_tvalid && !m_axis_tready)
        else $error("input stalled without output backpressure");

    // A zero-divisor result carries zero data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0)
        else $error("zero divisor with nonzero data");

endmodule

bind wide_integer_divider wid_checker u_wid_checker (.*);

// ===== tb/tb_wide_integer_divider.sv =====
// Testbench for the pipelined 256 by 128 bit signed/unsigned integer divider.
`timescale 1ns / 1ps

// Holds the quotient/remainder predictions for accepted divisions and checks
// each result beat against the oldest one.
class div_scoreboard;
    typedef struct {
        logic [255:0] quo;
        logic [127:0] rem;
        logic         div_zero;
    } div_result_t;

    div_result_t pending[$];
    int          mismatches;

    // Predict one division: restoring division on magnitudes, then signs.
    function void note_division(logic cmd, logic [255:0] num, logic [127:0] den);
        div_result_t  res;
        logic [255:0] num_mag;
        logic [127:0] den_mag;
        logic [128:0] part;
        logic         neg_num;
        logic         neg_den;
        neg_num = 1'b0;
        neg_den = 1'b0;
        res.quo = '0;
        res.rem = '0;
        res.div_zero = (den == '0);
        if (!res.div_zero)
        begin
            num_mag = num;
            den_mag = den;
            if (cmd == wid_pkg::CmdSigned)
            begin
                neg_num = num[255];
                neg_den = den[127];
                if (neg_num) num_mag = -num;
                if (neg_den) den_mag = -den;
            end
            part = '0;
            for (int i = 255; i >= 0; i--)
            begin
                part = {part[127:0], num_mag[i]};
                if (part >= {1'b0, den_mag})
                begin
                    part = part - {1'b0, den_mag};
                    res.quo[i] = 1'b1;
                end
            end
            res.rem = part[127:0];
            if (neg_num != neg_den) res.quo = -res.quo;
            if (neg_num) res.rem = -res.rem;
        end
        pending.push_back(res);
    endfunction

    function void check_result(logic [383:0] data, logic dz);
        div_result_t want;
        if (pending.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat: %h", data);
            return;
        end
        want = pending.pop_front();
        if (data[255:0] !== want.quo || data[383:256] !== want.rem || dz !== want.div_zero)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch: exp quo=%h rem=%h dz=%b got quo=%h rem=%h dz=%b",
                         want.quo, want.rem, want.div_zero, data[255:0], data[383:256], dz);
        end
    endfunction
endclass

module tb_wide_integer_divider;

    localparam int LatencyCycles = wid_pkg::DivStages + 2;
    localparam int IdleLimit     = 2000;
    localparam int RandomItems   = 500;

    logic         clk = 1'b0;
    logic         rst_n = 1'b0;
    logic         s_axis_tvalid = 1'b0;
    logic         s_axis_tready;
    logic [383:0] s_axis_tdata = '0;
    logic         s_axis_tuser = 1'b0;
    logic         m_axis_tvalid;
    logic         m_axis_tready = 1'b0;
    logic [383:0] m_axis_tdata;
    logic         m_axis_tuser;

    div_scoreboard divisions = new();
    int            idle_cycles = 0;

    always #2 clk = ~clk;

    wide_integer_divider uut (.*);

    // Send one division beat, after a random gap, and hold until accepted.
    task automatic send_division(logic cmd, logic [255:0] num, logic [127:0] den);
        int gap;
        gap = $urandom_range(0, 10);
        if ($urandom_range(0, 3) == 0) gap = 0;
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {den, num};
        s_axis_tuser  <= cmd;
        do @(posedge clk); while (!s_axis_tready);
        divisions.note_division(cmd, num, den);
    endtask

    // Wait until every predicted result has been checked.
    task automatic drain_results();
        while (divisions.pending.size() != 0) @(posedge clk);
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom(), $urandom()};
    endfunction

    // Word with a biased flavor: extremes, single set bits, small values or full random.
    function automatic logic [63:0] pick_word();
        case ($urandom_range(0, 5))
            0: return '0;
            1: return '1;
            2: return 64'(1) << $urandom_range(0, 63);
            3: return 64'($urandom_range(0, 15));
            default: return rand64();
        endcase
    endfunction

    // Receiver: random stall per beat, check on acceptance.
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = $urandom_range(0, 10);
            if ($urandom_range(0, 3) == 0) stall = 0;
            if (stall > 0)
            begin
                m_axis_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!m_axis_tvalid);
            divisions.check_result(m_axis_tdata, m_axis_tuser);
        end
    end

    // Watchdog: count cycles with no beat accepted on either side.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IdleLimit)
        begin
            $display("** wide_integer_divider: FAILED **");
            $finish;
        end
    end

    initial
    begin
        logic [255:0] num;
        logic [127:0] den;
        logic [255:0] min_num;
        logic [127:0] min_den;
        min_num = {1'b1, 255'b0};
        min_den = {1'b1, 127'b0};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: zero divisor, extremes, sign combinations, wrap case.
        send_division(wid_pkg::CmdUnsigned, '1, '0);
        send_division(wid_pkg::CmdSigned, min_num, '0);
        send_division(wid_pkg::CmdUnsigned, '1, '1);
        send_division(wid_pkg::CmdUnsigned, '1, 128'd1);
        send_division(wid_pkg::CmdUnsigned, '0, '1);
        send_division(wid_pkg::CmdUnsigned, '1, 128'h1_0000_0000_0000_0000);
        send_division(wid_pkg::CmdUnsigned, min_num, min_den);
        send_division(wid_pkg::CmdSigned, min_num, '1);           // wraps to itself
        send_division(wid_pkg::CmdSigned, min_num, 128'd1);
        send_division(wid_pkg::CmdSigned, min_num, min_den);      // divisor at 2^127
        send_division(wid_pkg::CmdSigned, 256'd7, min_den);
        send_division(wid_pkg::CmdSigned, -256'd7, min_den);
        send_division(wid_pkg::CmdSigned, 256'd7, 128'd2);
        send_division(wid_pkg::CmdSigned, -256'd7, 128'd2);
        send_division(wid_pkg::CmdSigned, 256'd7, -128'd2);
        send_division(wid_pkg::CmdSigned, -256'd7, -128'd2);
        send_division(wid_pkg::CmdSigned, '1, '1);
        send_division(wid_pkg::CmdSigned, {1'b0, {255{1'b1}}}, {1'b0, {127{1'b1}}});
        send_division(wid_pkg::CmdUnsigned, 256'd5, 128'd7);
        send_division(wid_pkg::CmdSigned, -256'd5, 128'd7);
        s_axis_tvalid <= 1'b0;

        // Hold off until every expected result has drained.
        drain_results();
        @(posedge clk);

        for (int k = 0; k < RandomItems; k++)
        begin
            num = {pick_word(), pick_word(), pick_word(), pick_word()};
            den = {pick_word(), pick_word()};
            if ($urandom_range(0, 3) == 0) den[127:64] = '0;   // 64-bit divisor
            if ($urandom_range(0, 3) == 0) den[127:64] = '1;   // small negative divisor
            send_division(1'($urandom_range(0, 1)), num, den);
        end
        s_axis_tvalid <= 1'b0;

        drain_results();
        repeat (LatencyCycles + 10) @(posedge clk);
        if (divisions.mismatches == 0 && divisions.pending.size() == 0)
            $display("** wide_integer_divider: PASSED **");
        else
            $display("** wide_integer_divider: FAILED **");
        $finish;
    end
endmodule
